/* design/vfa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vfa_pkg: shared definitions for the four-element fixed-point vector unit
// Operation codes, word widths and the saturation helper.
// ----------------------------------------------------------------------------
package vfa_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  // Wide enough for the exact sum of four full products.
  localparam int ACC_W     = 2 * WORD_BITS + 3;
  localparam int DIV_W     = WORD_BITS + FRAC_BITS;
  localparam int ROOT_W    = 2 * WORD_BITS - 1;

  localparam logic [4:0] OP_LOAD      = 5'd0;
  localparam logic [4:0] OP_BROADCAST = 5'd1;
  localparam logic [4:0] OP_SETELEM   = 5'd2;
  localparam logic [4:0] OP_ADD       = 5'd3;
  localparam logic [4:0] OP_SUB       = 5'd4;
  localparam logic [4:0] OP_SCALE     = 5'd5;
  localparam logic [4:0] OP_DIV       = 5'd6;
  localparam logic [4:0] OP_DOT4      = 5'd7;
  localparam logic [4:0] OP_DOT3      = 5'd8;
  localparam logic [4:0] OP_MAG4      = 5'd9;
  localparam logic [4:0] OP_MAG3      = 5'd10;
  localparam logic [4:0] OP_NORM4     = 5'd11;
  localparam logic [4:0] OP_NORM3     = 5'd12;
  localparam logic [4:0] OP_CROSS     = 5'd13;
  localparam logic [4:0] OP_PROJECT   = 5'd14;
  localparam logic [4:0] OP_MATROW    = 5'd15;
  localparam logic [4:0] OP_READ      = 5'd16;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [ACC_W-1:0]     acc_t;

  typedef struct packed {
    logic  ovf;
    word_t val;
  } sat_t;

  // Clamp a wide signed value to the word range and flag any clamping.
  function automatic sat_t sat_acc(input acc_t x);
    sat_t r;
    acc_t hi;
    acc_t lo;
    hi = {{(ACC_W-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
    lo = ~hi;
    if (x > hi) begin
      r.ovf = 1'b1;
      r.val = {1'b0, {(WORD_BITS-1){1'b1}}};
    end else if (x < lo) begin
      r.ovf = 1'b1;
      r.val = {1'b1, {(WORD_BITS-1){1'b0}}};
    end else begin
      r.ovf = 1'b0;
      r.val = x[WORD_BITS-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* design/vec4_fixed_point_alu_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vec4_fixed_point_alu_top: four-element Q16.16 vector math unit
// Holds one vector register and applies one operation per item, with
// saturating arithmetic and a fault flag.
// ----------------------------------------------------------------------------
// One item is taken at a time: in_ready is high only while the unit is idle,
// and the result is held on the output until it is taken. Products go
// through one shared 32x32 multiplier, one term at a time, so dot3, dot4 and
// cross step through their terms in turn. Magnitudes add a bit-serial square
// root. Division uses one restoring divider, one quotient at a time, for div,
// normalize and projection.
module vec4_fixed_point_alu_top
  import vfa_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output      logic                        in_ready,
  input  wire logic [4:0]                  op,
  input  wire logic [1:0]                  row_index,
  input  wire logic signed [WORD_BITS-1:0] operand_x,
  input  wire logic signed [WORD_BITS-1:0] operand_y,
  input  wire logic signed [WORD_BITS-1:0] operand_z,
  input  wire logic signed [WORD_BITS-1:0] operand_w,
  input  wire logic signed [WORD_BITS-1:0] scalar_in,
  output      logic                        out_valid,
  input  wire logic                        out_ready,
  output      logic signed [WORD_BITS-1:0] result_x,
  output      logic signed [WORD_BITS-1:0] result_y,
  output      logic signed [WORD_BITS-1:0] result_z,
  output      logic signed [WORD_BITS-1:0] result_w,
  output      logic signed [WORD_BITS-1:0] scalar_out,
  output      logic                        fault
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_MUL, S_ACC, S_SUM_END, S_SQRT, S_SQRT_END,
    S_DIV_START, S_DIV_STEP, S_DIV_END, S_OUT
  } state_t;

  localparam int DCNT_W = $clog2(DIV_W);

  state_t                    state;
  logic [4:0]                op_q;
  logic [1:0]                idx_q;
  word_t                     o_q [4];
  word_t                     s_q;
  word_t                     v [4];
  word_t                     rr [4];
  word_t                     cres [3];
  word_t                     scal_q;
  logic                      flt;
  acc_t                      acc;
  logic signed [2*WORD_BITS-1:0] prod;
  logic [2:0]                cnt;
  logic [1:0]                ph;
  word_t                     tmp;
  word_t                     msc;
  logic [ROOT_W-1:0]         sq_rem;
  logic [ROOT_W-1:0]         sq_root;
  logic [4:0]                sq_k;
  logic [WORD_BITS-1:0]      dv_rem;
  logic [DIV_W-1:0]          dv_q;
  logic [WORD_BITS-1:0]      dv_dvs;
  logic                      dv_neg;
  logic [DCNT_W-1:0]         dv_cnt;

  // Multiplier operand selection.
  word_t                         mul_a;
  word_t                         mul_b;
  logic                          mul_neg;
  logic [2:0]                    last_cnt;
  logic signed [2*WORD_BITS-1:0] mul_p;
  logic                          is_mag;
  logic                          elemwise;

  always_comb begin
    mul_a    = v[cnt[1:0]];
    mul_b    = o_q[cnt[1:0]];
    mul_neg  = 1'b0;
    last_cnt = 3'd3;
    if (op_q == OP_MAG4 || op_q == OP_MAG3 || op_q == OP_NORM4 || op_q == OP_NORM3) begin
      mul_b = v[cnt[1:0]];
    end else if (op_q == OP_SCALE) begin
      mul_b = s_q;
    end else if (op_q == OP_PROJECT && ph == 2'd1) begin
      mul_a = o_q[cnt[1:0]];
    end else if (op_q == OP_PROJECT && ph == 2'd2) begin
      mul_a = o_q[cnt[1:0]];
      mul_b = tmp;
    end else if (op_q == OP_CROSS) begin
      last_cnt = 3'd5;
      mul_neg  = cnt[0];
      unique case (cnt)
        3'd0:    begin mul_a = v[1]; mul_b = o_q[2]; end
        3'd1:    begin mul_a = v[2]; mul_b = o_q[1]; end
        3'd2:    begin mul_a = v[2]; mul_b = o_q[0]; end
        3'd3:    begin mul_a = v[0]; mul_b = o_q[2]; end
        3'd4:    begin mul_a = v[0]; mul_b = o_q[1]; end
        default: begin mul_a = v[1]; mul_b = o_q[0]; end
      endcase
    end
    if (op_q == OP_DOT3 || op_q == OP_MAG3 || op_q == OP_NORM3 ||
        (op_q == OP_PROJECT && ph == 2'd1)) begin
      last_cnt = 3'd2;
    end
  end

  assign mul_p    = mul_a * mul_b;
  assign is_mag   = (op_q == OP_MAG4 || op_q == OP_MAG3 || op_q == OP_NORM4 ||
                     op_q == OP_NORM3 || (op_q == OP_PROJECT && ph == 2'd1));
  assign elemwise = (op_q == OP_SCALE || (op_q == OP_PROJECT && ph == 2'd2));

  acc_t prod_ext;
  acc_t acc_sum;
  sat_t sat_dot;
  sat_t sat_elem;
  sat_t sat_cross;
  logic mag_ovf;

  assign prod_ext  = ACC_W'(prod);
  assign acc_sum   = acc + prod_ext;
  assign sat_dot   = sat_acc(acc >>> FRAC_BITS);
  assign sat_elem  = sat_acc(prod_ext >>> FRAC_BITS);
  assign sat_cross = sat_acc(acc_sum >>> FRAC_BITS);
  assign mag_ovf   = (acc >= $signed(ACC_W'(1) << (2 * (WORD_BITS - 1))));

  // Square root step.
  logic [ROOT_W-1:0] sq_bit;
  logic [ROOT_W-1:0] sq_try;
  word_t             root_w;

  assign sq_bit = ROOT_W'(1) << {sq_k, 1'b0};
  assign sq_try = sq_root + sq_bit;
  assign root_w = sq_root[WORD_BITS-1:0];

  // Divider start operands and step.
  word_t                dvd_sel;
  word_t                dvs_sel;
  logic [WORD_BITS-1:0] dvd_mag;
  logic [WORD_BITS-1:0] dvs_mag;
  logic [WORD_BITS:0]   rem_sh;
  logic                 dv_ge;
  logic [WORD_BITS:0]   rem_sub;
  acc_t                 quo_pos;
  sat_t                 sat_div;

  assign dvd_sel = (op_q == OP_PROJECT) ? tmp : v[cnt[1:0]];
  assign dvs_sel = (op_q == OP_DIV) ? s_q : msc;
  assign dvd_mag = dvd_sel[WORD_BITS-1] ? WORD_BITS'(-dvd_sel) : WORD_BITS'(dvd_sel);
  assign dvs_mag = dvs_sel[WORD_BITS-1] ? WORD_BITS'(-dvs_sel) : WORD_BITS'(dvs_sel);
  assign rem_sh  = {dv_rem, dv_q[DIV_W-1]};
  assign dv_ge   = (rem_sh >= {1'b0, dv_dvs});
  assign rem_sub = rem_sh - {1'b0, dv_dvs};
  assign quo_pos = ACC_W'(dv_q);
  assign sat_div = sat_acc(dv_neg ? -quo_pos : quo_pos);

  // Add and subtract for all four elements.
  sat_t sat_add [4];
  sat_t sat_sub [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sat_add[i] = sat_acc(ACC_W'(v[i]) + ACC_W'(o_q[i]));
      sat_sub[i] = sat_acc(ACC_W'(v[i]) - ACC_W'(o_q[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < 4; i++) begin
        v[i]  <= '0;
        rr[i] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_q   <= op;
            idx_q  <= row_index;
            o_q[0] <= operand_x;
            o_q[1] <= operand_y;
            o_q[2] <= operand_z;
            o_q[3] <= operand_w;
            s_q    <= scalar_in;
            scal_q <= '0;
            flt    <= 1'b0;
            state  <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          acc   <= '0;
          cnt   <= '0;
          ph    <= '0;
          state <= S_OUT;
          case (op_q)
            OP_LOAD: begin
              for (int i = 0; i < 4; i++) v[i] <= o_q[i];
            end
            OP_BROADCAST: begin
              for (int i = 0; i < 4; i++) v[i] <= s_q;
            end
            OP_SETELEM: v[idx_q] <= s_q;
            OP_ADD: begin
              for (int i = 0; i < 4; i++) v[i] <= sat_add[i].val;
              flt <= sat_add[0].ovf | sat_add[1].ovf | sat_add[2].ovf | sat_add[3].ovf;
            end
            OP_SUB: begin
              for (int i = 0; i < 4; i++) v[i] <= sat_sub[i].val;
              flt <= sat_sub[0].ovf | sat_sub[1].ovf | sat_sub[2].ovf | sat_sub[3].ovf;
            end
            OP_DIV: begin
              if (s_q == '0) begin
                flt <= 1'b1;
              end else begin
                state <= S_DIV_START;
              end
            end
            OP_SCALE, OP_DOT4, OP_DOT3, OP_MAG4, OP_MAG3, OP_NORM4, OP_NORM3,
            OP_CROSS, OP_PROJECT, OP_MATROW: state <= S_MUL;
            default: state <= S_OUT;
          endcase
        end
        S_MUL: begin
          prod  <= mul_neg ? -mul_p : mul_p;
          state <= S_ACC;
        end
        S_ACC: begin
          acc <= acc_sum;
          if (elemwise) begin
            v[cnt[1:0]] <= sat_elem.val;
            flt         <= flt | sat_elem.ovf;
          end
          if (op_q == OP_CROSS && cnt[0]) begin
            // Each pair of terms closes one element of the cross product.
            cres[cnt[2:1]] <= sat_cross.val;
            flt            <= flt | sat_cross.ovf;
            acc            <= '0;
          end
          if (cnt == last_cnt) begin
            state <= S_SUM_END;
          end else begin
            cnt   <= cnt + 3'd1;
            state <= S_MUL;
          end
        end
        S_SUM_END: begin
          state <= S_OUT;
          if (is_mag) begin
            sq_rem  <= acc[ROOT_W-1:0];
            sq_root <= '0;
            sq_k    <= 5'(WORD_BITS - 2);
            if (mag_ovf) begin
              flt     <= 1'b1;
              sq_root <= ROOT_W'({1'b0, {(WORD_BITS-1){1'b1}}});
              state   <= S_SQRT_END;
            end else begin
              state <= S_SQRT;
            end
          end else if (op_q == OP_DOT4 || op_q == OP_DOT3) begin
            scal_q <= sat_dot.val;
            flt    <= flt | sat_dot.ovf;
          end else if (op_q == OP_MATROW) begin
            scal_q     <= sat_dot.val;
            flt        <= flt | sat_dot.ovf;
            rr[idx_q]  <= sat_dot.val;
            if (idx_q == 2'd3) begin
              v[0] <= rr[0];
              v[1] <= rr[1];
              v[2] <= rr[2];
              v[3] <= sat_dot.val;
            end
          end else if (op_q == OP_PROJECT && ph == 2'd0) begin
            // Dot first, then the operand's three-element length.
            tmp   <= sat_dot.val;
            flt   <= flt | sat_dot.ovf;
            ph    <= 2'd1;
            cnt   <= '0;
            acc   <= '0;
            state <= S_MUL;
          end
        end
        S_SQRT: begin
          if (sq_rem >= sq_try) begin
            sq_rem  <= sq_rem - sq_try;
            sq_root <= (sq_root >> 1) + sq_bit;
          end else begin
            sq_root <= sq_root >> 1;
          end
          sq_k <= sq_k - 5'd1;
          if (sq_k == '0) state <= S_SQRT_END;
        end
        S_SQRT_END: begin
          state <= S_OUT;
          if (op_q == OP_MAG4 || op_q == OP_MAG3) begin
            scal_q <= root_w;
          end else if (op_q == OP_PROJECT) begin
            if (root_w == '0) begin
              flt <= 1'b1;
            end else begin
              msc   <= root_w;
              state <= S_DIV_START;
            end
          end else begin
            scal_q <= root_w;
            cnt    <= '0;
            if (root_w == '0) begin
              flt <= 1'b1;
            end else begin
              msc   <= root_w;
              state <= S_DIV_START;
            end
          end
        end
        S_DIV_START: begin
          dv_q   <= {dvd_mag, {FRAC_BITS{1'b0}}};
          dv_dvs <= dvs_mag;
          dv_rem <= '0;
          dv_neg <= dvd_sel[WORD_BITS-1] ^ dvs_sel[WORD_BITS-1];
          dv_cnt <= '0;
          state  <= S_DIV_STEP;
        end
        S_DIV_STEP: begin
          dv_rem <= dv_ge ? rem_sub[WORD_BITS-1:0] : rem_sh[WORD_BITS-1:0];
          dv_q   <= {dv_q[DIV_W-2:0], dv_ge};
          dv_cnt <= dv_cnt + 1'b1;
          if (dv_cnt == DCNT_W'(DIV_W - 1)) state <= S_DIV_END;
        end
        S_DIV_END: begin
          flt <= flt | sat_div.ovf;
          if (op_q == OP_PROJECT) begin
            tmp   <= sat_div.val;
            ph    <= 2'd2;
            cnt   <= '0;
            acc   <= '0;
            state <= S_MUL;
          end else begin
            v[cnt[1:0]] <= sat_div.val;
            if (cnt == 3'd3) begin
              state <= S_OUT;
            end else begin
              cnt   <= cnt + 3'd1;
              state <= S_DIV_START;
            end
          end
        end
        S_OUT: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready   = (state == S_IDLE);
  assign out_valid  = (state == S_OUT);
  assign result_x   = (op_q == OP_CROSS) ? cres[0] : v[0];
  assign result_y   = (op_q == OP_CROSS) ? cres[1] : v[1];
  assign result_z   = (op_q == OP_CROSS) ? cres[2] : v[2];
  assign result_w   = v[3];
  assign scalar_out = scal_q;
  assign fault      = flt;

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output handshakes open at once");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !out_valid)
    else $error("result shown in the cycle after an item is taken");

  a_div_zero_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid && op_q == OP_DIV && s_q == '0 |-> fault)
    else $error("division by zero without fault");

  a_no_scalar: assert property (@(posedge clk) disable iff (rst)
    out_valid && (op_q == OP_LOAD || op_q == OP_ADD || op_q == OP_SCALE ||
                  op_q == OP_DIV || op_q == OP_CROSS) |-> scalar_out == '0)
    else $error("scalar result on an operation that has none");

endmodule
`default_nettype wire
